@@ hdl/cst_pkg.sv @@
`default_nettype none

package cst_pkg;

    // most results a single byte can produce (0 then x then a non-hex byte)
    localparam int MAX_RES     = 4;
    localparam int CNT_W       = 3;
    localparam int QUEUE_DEPTH = 8;

    // token classes
    localparam logic [3:0] TT_UNKNOWN = 4'd0;
    localparam logic [3:0] TT_NUMBER  = 4'd1;
    localparam logic [3:0] TT_STRING  = 4'd2;
    localparam logic [3:0] TT_CHAR    = 4'd3;
    localparam logic [3:0] TT_IDENT   = 4'd4;
    localparam logic [3:0] TT_LPAREN  = 4'd5;
    localparam logic [3:0] TT_RPAREN  = 4'd6;
    localparam logic [3:0] TT_LBRACK  = 4'd7;
    localparam logic [3:0] TT_RBRACK  = 4'd8;
    localparam logic [3:0] TT_HASH    = 4'd9;
    localparam logic [3:0] TT_WHITE   = 4'd10;
    localparam logic [3:0] TT_LESS    = 4'd11;
    localparam logic [3:0] TT_GREATER = 4'd12;
    localparam logic [3:0] TT_COMMA   = 4'd13;
    localparam logic [3:0] TT_ARROW   = 4'd14;
    localparam logic [3:0] TT_SEMI    = 4'd15;

    // register map
    localparam logic REG_SKIP_WS = 1'b0;

    // control characters
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_SQ  = 8'h27;
    localparam logic [7:0] CH_BSL = 8'h5C;

    typedef struct packed {
        logic       stream_done;
        logic       token_last;
        logic [3:0] tok_class;
        logic       char_valid;
        logic [7:0] out_char;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0]        count;
        item_t [MAX_RES-1:0]     item;
    } lex_out_t;

endpackage

`default_nettype wire

@@ hdl/c_source_tokenizer.sv @@
// C source tokenizer.
// Input stream (s_*): one source byte per request in s_tdata; s_tlast high marks
// end of input, which flushes the pending token (s_tdata is then ignored).
// Output stream (m_*): one token character or token marker per request.
// m_tdata carries the character, m_tlast marks the last item of a token, and
// m_tuser carries char_valid, the token class and the end-of-stream flag.
// Each accepted byte yields 0 to 4 result items, all written together into a
// QUEUE_DEPTH entry output queue, a register array from which m_* is read.
// Throughput is one byte per cycle while m_tready is high and bytes average
// one result or fewer; the output drains at most one item per cycle, so bytes
// that expand to several items (token ends found only on the next byte,
// escapes, 0x pairs) stall input until the queue has room for the worst case, 4 items.
// s_tready drops while fewer than 4 queue entries are free, so a stalled
// receiver backs up into the input once more than QUEUE_DEPTH-4 items wait.
// Reset (aresetn low, synchronous) empties the queue, returns the lexer to
// idle between tokens and sets ws_skip to 1. The APB register at
// address 0 holds ws_skip; write it only while the block is idle.
`default_nettype none

module c_source_tokenizer #(
    parameter int QUEUE_DEPTH = cst_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_char
    input  wire logic        s_tlast,   // end_of_input
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_char
    output logic [5:0]       m_tuser,   // [0] char_valid, [4:1] tok_class, [5] stream_done
    output logic             m_tlast,   // token_last
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import cst_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          skip_reg;
    lex_out_t      lex_out;
    logic          s_accept;
    logic          m_accept;

    item_t         q_mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] q_count_reg, q_count_next;
    item_t         head;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SKIP_WS) ? {31'd0, skip_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SKIP_WS)) begin
            skip_reg <= pwdata[0];
        end
    end

    assign s_tready = (q_count_reg <= CW'(QUEUE_DEPTH - MAX_RES));
    assign s_accept = s_tvalid && s_tready;

    cst_lexer u_lexer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_accept),
        .in_char   (s_tdata),
        .in_end    (s_tlast),
        .skip_ws   (skip_reg),
        .lex_out   (lex_out)
    );

    // result queue: up to MAX_RES writes per cycle, one read
    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (CNT_W'(k) < lex_out.count) begin
                q_mem[wr_ptr_reg + PW'(k)] <= lex_out.item[k];
            end
        end
    end

    assign m_accept     = m_tvalid && m_tready;
    assign q_count_next = q_count_reg + CW'(lex_out.count) - CW'(m_accept);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end else begin
            wr_ptr_reg  <= wr_ptr_reg + PW'(lex_out.count);
            rd_ptr_reg  <= rd_ptr_reg + PW'(m_accept);
            q_count_reg <= q_count_next;
        end
    end

    assign head     = q_mem[rd_ptr_reg];
    assign m_tvalid = (q_count_reg != '0);
    assign m_tdata  = head.out_char;
    assign m_tuser  = {head.stream_done, head.tok_class, head.char_valid};
    assign m_tlast  = head.token_last;

endmodule

`default_nettype wire

@@ hdl/cst_lexer.sv @@
`default_nettype none

module cst_lexer (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_accept,
    input  wire logic [7:0]       in_char,
    input  wire logic             in_end,
    input  wire logic             skip_ws,
    output cst_pkg::lex_out_t     lex_out
);
    import cst_pkg::*;

    localparam logic [3:0] M_IDLE  = 4'd0;
    localparam logic [3:0] M_SLASH = 4'd1;
    localparam logic [3:0] M_LINE  = 4'd2;
    localparam logic [3:0] M_BLOCK = 4'd3;
    localparam logic [3:0] M_BSTAR = 4'd4;
    localparam logic [3:0] M_ZERO  = 4'd5;
    localparam logic [3:0] M_ZEROX = 4'd6;
    localparam logic [3:0] M_DEC   = 4'd7;
    localparam logic [3:0] M_OCT   = 4'd8;
    localparam logic [3:0] M_HEX   = 4'd9;
    localparam logic [3:0] M_IDENT = 4'd10;
    localparam logic [3:0] M_LIT   = 4'd11;
    localparam logic [3:0] M_ESC   = 4'd12;
    localparam logic [3:0] M_OP    = 4'd13;
    localparam logic [3:0] M_MINUS = 4'd14;

    logic [3:0] mode_reg, mode_next;
    logic [7:0] held_reg, held_next;
    logic [7:0] op_reg, op_next;
    logic       quote_reg, quote_next;

    function automatic item_t mk_item(logic [7:0] ch, logic valid, logic [3:0] ty, logic last);
        item_t it;
        it.out_char    = valid ? ch : 8'd0;
        it.char_valid  = valid;
        it.tok_class   = last ? ty : TT_UNKNOWN;
        it.token_last  = last;
        it.stream_done = 1'b0;
        return it;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    item_t [MAX_RES-1:0] items;
    logic [CNT_W-1:0]    cnt;
    logic [1:0]          last_idx;
    logic                redo;
    logic [3:0]          lit_ty;

    assign lit_ty = quote_reg ? TT_CHAR : TT_STRING;

    always_comb begin
        mode_next  = mode_reg;
        held_next  = held_reg;
        op_next    = op_reg;
        quote_next = quote_reg;
        items      = '0;
        cnt        = '0;
        redo       = 1'b0;
        last_idx   = '0;

        if (in_end) begin
            unique case (mode_reg)
                M_ZERO, M_DEC, M_OCT, M_HEX: begin
                    items[cnt[1:0]] = mk_item(8'd0, 1'b0, TT_NUMBER, 1'b1); cnt = cnt + 3'd1;
                end
                M_ZEROX: begin
                    items[cnt[1:0]] = mk_item(8'd0, 1'b0, TT_NUMBER, 1'b1); cnt = cnt + 3'd1;
                    items[cnt[1:0]] = mk_item(held_reg, 1'b1, TT_UNKNOWN, 1'b0);
                    cnt = cnt + 3'd1;
                    items[cnt[1:0]] = mk_item(8'd0, 1'b0, TT_IDENT, 1'b1); cnt = cnt + 3'd1;
                end
                M_IDENT: begin
                    items[cnt[1:0]] = mk_item(8'd0, 1'b0, TT_IDENT, 1'b1); cnt = cnt + 3'd1;
                end
                M_LIT, M_ESC: begin
                    items[cnt[1:0]] = mk_item(8'd0, 1'b0, lit_ty, 1'b1); cnt = cnt + 3'd1;
                end
                M_OP, M_MINUS: begin
                    items[cnt[1:0]] = mk_item(8'd0, 1'b0, TT_UNKNOWN, 1'b1); cnt = cnt + 3'd1;
                end
                default: ;
            endcase
            // nothing pending: a bare end marker
            if (cnt == 3'd0) begin
                items[0] = mk_item(8'd0, 1'b0, TT_UNKNOWN, 1'b0);
                cnt      = 3'd1;
            end
            last_idx = 2'(cnt - 3'd1);
            items[last_idx].stream_done = 1'b1;
            mode_next  = M_IDLE;
            held_next  = 8'd0;
            op_next    = 8'd0;
            quote_next = 1'b0;
        end else begin
            unique case (mode_reg)
                M_IDLE: redo = 1'b1;
                M_SLASH: begin
                    if (in_char == "/") begin
                        mode_next = M_LINE;
                    end else if (in_char == "*") begin
                        mode_next = M_BLOCK;
                    end else begin
                        items[cnt[1:0]] = mk_item("/", 1'b1, TT_UNKNOWN, 1'b1);
                        cnt = cnt + 3'd1;
                        redo = 1'b1;
                    end
                end
                M_LINE: begin
                    if (in_char == CH_LF) mode_next = M_IDLE;
                end
                M_BLOCK: begin
                    if (in_char == "*") mode_next = M_BSTAR;
                end
                M_BSTAR: begin
                    if (in_char == "/") begin
                        mode_next = M_IDLE;
                    end else if (in_char != "*") begin
                        mode_next = M_BLOCK;
                    end
                end
                M_ZERO: begin
                    if ((in_char >= "0") && (in_char <= "8")) begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_UNKNOWN, 1'b0);
                        cnt = cnt + 3'd1;
                        mode_next = M_OCT;
                    end else if ((in_char == "x") || (in_char == "X")) begin
                        held_next = in_char;
                        mode_next = M_ZEROX;
                    end else begin
                        items[cnt[1:0]] = mk_item(8'd0, 1'b0, TT_NUMBER, 1'b1);
                        cnt = cnt + 3'd1;
                        redo = 1'b1;
                    end
                end
                M_ZEROX: begin
                    held_next = 8'd0;
                    if (is_hex(in_char)) begin
                        items[cnt[1:0]] = mk_item(held_reg, 1'b1, TT_UNKNOWN, 1'b0);
                        cnt = cnt + 3'd1;
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_UNKNOWN, 1'b0);
                        cnt = cnt + 3'd1;
                        mode_next = M_HEX;
                    end else begin
                        // "0" ends; the held x starts an identifier, joined by an ident byte
                        items[cnt[1:0]] = mk_item(8'd0, 1'b0, TT_NUMBER, 1'b1);
                        cnt = cnt + 3'd1;
                        items[cnt[1:0]] = mk_item(held_reg, 1'b1, TT_UNKNOWN, 1'b0);
                        cnt = cnt + 3'd1;
                        if (is_alpha(in_char) || is_digit(in_char) || (in_char == "_")) begin
                            items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_UNKNOWN, 1'b0);
                            cnt = cnt + 3'd1;
                            mode_next = M_IDENT;
                        end else begin
                            items[cnt[1:0]] = mk_item(8'd0, 1'b0, TT_IDENT, 1'b1);
                            cnt = cnt + 3'd1;
                            redo = 1'b1;
                        end
                    end
                end
                M_DEC, M_OCT, M_HEX: begin
                    if ((mode_reg == M_HEX) ? is_hex(in_char) :
                        (mode_reg == M_OCT) ? ((in_char >= "0") && (in_char <= "8")) :
                        is_digit(in_char)) begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_UNKNOWN, 1'b0);
                        cnt = cnt + 3'd1;
                    end else begin
                        items[cnt[1:0]] = mk_item(8'd0, 1'b0, TT_NUMBER, 1'b1);
                        cnt = cnt + 3'd1;
                        redo = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(in_char) || is_digit(in_char) || (in_char == "_")) begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_UNKNOWN, 1'b0);
                        cnt = cnt + 3'd1;
                    end else begin
                        items[cnt[1:0]] = mk_item(8'd0, 1'b0, TT_IDENT, 1'b1);
                        cnt = cnt + 3'd1;
                        redo = 1'b1;
                    end
                end
                M_LIT: begin
                    if (in_char == CH_BSL) begin
                        mode_next = M_ESC;
                    end else if (in_char == (quote_reg ? CH_SQ : CH_DQ)) begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, lit_ty, 1'b1);
                        cnt = cnt + 3'd1;
                        mode_next = M_IDLE;
                    end else begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_UNKNOWN, 1'b0);
                        cnt = cnt + 3'd1;
                    end
                end
                M_ESC: begin
                    items[cnt[1:0]] = mk_item(CH_BSL, 1'b1, TT_UNKNOWN, 1'b0);
                    cnt = cnt + 3'd1;
                    items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_UNKNOWN, 1'b0);
                    cnt = cnt + 3'd1;
                    mode_next = M_LIT;
                end
                M_OP: begin
                    if (in_char == op_reg) begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_UNKNOWN, 1'b1);
                        cnt = cnt + 3'd1;
                        mode_next = M_IDLE;
                    end else begin
                        items[cnt[1:0]] = mk_item(8'd0, 1'b0, TT_UNKNOWN, 1'b1);
                        cnt = cnt + 3'd1;
                        redo = 1'b1;
                    end
                end
                M_MINUS: begin
                    if (in_char == "-") begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_UNKNOWN, 1'b1);
                        cnt = cnt + 3'd1;
                        mode_next = M_IDLE;
                    end else if (in_char == ">") begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_ARROW, 1'b1);
                        cnt = cnt + 3'd1;
                        mode_next = M_IDLE;
                    end else begin
                        items[cnt[1:0]] = mk_item(8'd0, 1'b0, TT_UNKNOWN, 1'b1);
                        cnt = cnt + 3'd1;
                        redo = 1'b1;
                    end
                end
                default: redo = 1'b1;
            endcase

            // byte rescanned between tokens
            if (redo) begin
                mode_next = M_IDLE;
                unique case (in_char)
                    "/": mode_next = M_SLASH;
                    "#": begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_HASH, 1'b1);
                        cnt = cnt + 3'd1;
                    end
                    " ", CH_TAB, CH_CR, CH_LF, CH_BSL: begin
                        if (!skip_ws) begin
                            items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_WHITE, 1'b1);
                            cnt = cnt + 3'd1;
                        end
                    end
                    "(": begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_LPAREN, 1'b1);
                        cnt = cnt + 3'd1;
                    end
                    ")": begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_RPAREN, 1'b1);
                        cnt = cnt + 3'd1;
                    end
                    "[": begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_LBRACK, 1'b1);
                        cnt = cnt + 3'd1;
                    end
                    "]": begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_RBRACK, 1'b1);
                        cnt = cnt + 3'd1;
                    end
                    "<": begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_LESS, 1'b1);
                        cnt = cnt + 3'd1;
                    end
                    ">": begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_GREATER, 1'b1);
                        cnt = cnt + 3'd1;
                    end
                    ",": begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_COMMA, 1'b1);
                        cnt = cnt + 3'd1;
                    end
                    ";": begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_SEMI, 1'b1);
                        cnt = cnt + 3'd1;
                    end
                    "{", "}", ":", "~", "?", "*", "%", "!", ".": begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_UNKNOWN, 1'b1);
                        cnt = cnt + 3'd1;
                    end
                    "0": begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_UNKNOWN, 1'b0);
                        cnt = cnt + 3'd1;
                        mode_next = M_ZERO;
                    end
                    CH_DQ, CH_SQ: begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_UNKNOWN, 1'b0);
                        cnt = cnt + 3'd1;
                        quote_next = (in_char == CH_SQ);
                        mode_next  = M_LIT;
                    end
                    "+", "=", "|", "&": begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_UNKNOWN, 1'b0);
                        cnt = cnt + 3'd1;
                        op_next   = in_char;
                        mode_next = M_OP;
                    end
                    "-": begin
                        items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_UNKNOWN, 1'b0);
                        cnt = cnt + 3'd1;
                        mode_next = M_MINUS;
                    end
                    default: begin
                        if (is_digit(in_char)) begin
                            items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_UNKNOWN, 1'b0);
                            cnt = cnt + 3'd1;
                            mode_next = M_DEC;
                        end else if (is_alpha(in_char)) begin
                            items[cnt[1:0]] = mk_item(in_char, 1'b1, TT_UNKNOWN, 1'b0);
                            cnt = cnt + 3'd1;
                            mode_next = M_IDENT;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            held_reg  <= 8'd0;
            op_reg    <= 8'd0;
            quote_reg <= 1'b0;
        end else if (in_accept) begin
            mode_reg  <= mode_next;
            held_reg  <= held_next;
            op_reg    <= op_next;
            quote_reg <= quote_next;
        end
    end

    assign lex_out.count = in_accept ? cnt : '0;
    assign lex_out.item  = items;

endmodule

`default_nettype wire

@@ hdl/cst_checker.sv @@
`default_nettype none

module cst_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [5:0] m_tuser,
    input wire logic       m_tlast
);

    // queue empties on reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result queue not empty after reset");

    // a held result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    a_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
        else $error("character without char_valid");

    a_type_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[4:1] == 4'd0)
        else $error("token type outside last item");

    // end of stream closes on a marker, never on a character
    a_done_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[5] |-> !m_tuser[0])
        else $error("stream_done on a character item");

endmodule

bind c_source_tokenizer cst_checker u_cst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
